### src/msp_pkg.sv
package msp_pkg;

  // default sizes
  localparam int DEF_NUM_STACKS = 4;
  localparam int DEF_POOL_SLOTS = 16;

  localparam int VALUE_W = 32;

  // operation codes on the func field
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  // outcome of the operation held in the stage register
  typedef struct packed {
    logic    push_ok;
    logic    pop_ok;
    status_e status;
    logic    stack_empty;
    logic    pool_full;
  } op_flags_t;

endpackage

### src/msp_ram.sv
module msp_ram #(
  parameter int WIDTH = msp_pkg::VALUE_W,
  parameter int DEPTH = msp_pkg::DEF_POOL_SLOTS,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/msp_list.sv
module msp_list #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int POOL_SLOTS = msp_pkg::DEF_POOL_SLOTS,
  localparam int IdxW = $clog2(POOL_SLOTS + 1),
  localparam int SidW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item in the stage register, committed when commit_i is high
  input  logic                commit_i,
  input  logic                s1_func_i,
  input  logic [SidW-1:0]     s1_sid_i,
  input  logic [IdxW-1:0]     s1_slot_i,
  input  logic [IdxW-1:0]     link_rd_i,
  // item being transferred in
  input  logic                acc_func_i,
  input  logic [SidW-1:0]     acc_sid_i,
  output logic [IdxW-1:0]     rd_slot_o,
  output logic                fwd_hit_o,
  output logic [IdxW-1:0]     fwd_link_o,
  // link write and outcome of the staged item
  output logic [IdxW-1:0]     wr_link_o,
  output msp_pkg::op_flags_t  flags_o
);

  localparam logic [IdxW-1:0] NullLink = IdxW'(POOL_SLOTS);

  logic [IdxW-1:0] head_q [NUM_STACKS];
  logic [IdxW-1:0] head_d [NUM_STACKS];
  logic [IdxW-1:0] free_q, free_d;
  // slots at and above fill_q were never taken, their link is implied
  logic [IdxW-1:0] fill_q, fill_d;

  logic            slot_null;
  logic            push_ok, pop_ok;
  logic [IdxW-1:0] link_nx;
  logic [IdxW-1:0] new_head, new_free;
  logic            wr_hit, fresh;

  assign link_nx   = (link_rd_i >= NullLink) ? NullLink : link_rd_i;
  assign slot_null = (s1_slot_i >= NullLink);
  assign push_ok   = (s1_func_i == msp_pkg::FUNC_PUSH) && !slot_null;
  assign pop_ok    = (s1_func_i == msp_pkg::FUNC_POP) && !slot_null;

  assign wr_link_o = (s1_func_i == msp_pkg::FUNC_PUSH) ? head_q[s1_sid_i] : free_q;

  always_comb begin
    new_head = head_q[s1_sid_i];
    new_free = free_q;
    if (push_ok) begin
      new_head = s1_slot_i;
      new_free = link_nx;
    end else if (pop_ok) begin
      new_head = link_nx;
      new_free = s1_slot_i;
    end
  end

  always_comb begin
    flags_o.push_ok     = push_ok;
    flags_o.pop_ok      = pop_ok;
    flags_o.stack_empty = (new_head >= NullLink);
    flags_o.pool_full   = (new_free >= NullLink);
    if (!slot_null) begin
      flags_o.status = msp_pkg::STATUS_OK;
    end else if (s1_func_i == msp_pkg::FUNC_PUSH) begin
      flags_o.status = msp_pkg::STATUS_OVERFLOW;
    end else begin
      flags_o.status = msp_pkg::STATUS_UNDERFLOW;
    end
  end

  always_comb begin
    head_d = head_q;
    free_d = free_q;
    fill_d = fill_q;
    if (commit_i && (push_ok || pop_ok)) begin
      head_d[s1_sid_i] = new_head;
      free_d           = new_free;
      if (push_ok && (s1_slot_i == fill_q)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  // next item reads the slot it will touch, from the updated pointers
  assign rd_slot_o = (acc_func_i == msp_pkg::FUNC_PUSH) ? free_d : head_d[acc_sid_i];

  // slot written this cycle, or a never-used slot whose link is implied
  assign wr_hit     = commit_i && (push_ok || pop_ok) && (rd_slot_o == s1_slot_i);
  assign fresh      = (acc_func_i == msp_pkg::FUNC_PUSH) && (free_d < NullLink)
                      && (free_d == fill_d);
  assign fwd_hit_o  = wr_hit || fresh;
  assign fwd_link_o = wr_hit ? wr_link_o : (fill_d + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_STACKS; k++) begin
        head_q[k] <= NullLink;
      end
      free_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      free_q <= free_d;
      fill_q <= fill_d;
    end
  end

endmodule

### src/multi_stack_shared_pool_unit.sv
// NUM_STACKS independent LIFO stacks sharing one pool of POOL_SLOTS slots. Each input
// transfer is a push of item_value_i (func_i = 0) or a pop (func_i = 1) on stack
// stack_id_i, which wraps modulo NUM_STACKS. Every input transfer gives exactly one
// result transfer, in order: popped_value_o (zero unless a pop succeeded), status_o
// (0 ok, 1 push on a full pool, 2 pop from an empty stack; neither changes any state),
// and stack_empty_o / pool_full_o as they stand after the operation. The block takes
// one item per cycle while the result channel does not stall; a result passes the
// stage register and then the result register. The slot link and value RAMs are read
// on the input transfer, and the pointer update happens as the item leaves the stage
// register, from which the next item's read address is formed directly. Stalls on
// the output hold the item in the stage register. No clearing pass is needed after
// reset: never-used slots get their link from a fill counter.
module multi_stack_shared_pool_unit #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int POOL_SLOTS = msp_pkg::DEF_POOL_SLOTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [1:0]                        stack_id_i,
  input  logic signed [msp_pkg::VALUE_W-1:0] item_value_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [msp_pkg::VALUE_W-1:0] popped_value_o,
  output logic [1:0]                        status_o,
  output logic                              stack_empty_o,
  output logic                              pool_full_o
);

  localparam int IdxW  = $clog2(POOL_SLOTS + 1);
  localparam int AddrW = $clog2(POOL_SLOTS);
  localparam int SidW  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int ValW  = msp_pkg::VALUE_W;

  // handshake
  logic accept, adv;

  // stage register: item whose RAM reads are in flight
  logic                   s1_valid_q, s1_valid_d;
  logic                   s1_func_q;
  logic [SidW-1:0]        s1_sid_q;
  logic signed [ValW-1:0] s1_value_q;
  logic [IdxW-1:0]        s1_slot_q;
  logic                   s1_fwd_q;
  logic [IdxW-1:0]        s1_fwd_link_q;
  logic signed [ValW-1:0] s1_fwd_val_q;

  // result register
  logic                   out_valid_q, out_valid_d;
  logic signed [ValW-1:0] popped_q;
  msp_pkg::status_e       status_q;
  logic                   empty_q, full_q;

  // incoming item
  logic [1:0]             sid_red;
  logic [SidW-1:0]        acc_sid;
  logic [IdxW-1:0]        rd_slot;
  logic                   fwd_hit;
  logic [IdxW-1:0]        fwd_link;

  // staged item
  logic [IdxW-1:0]        link_ram_q;
  logic [ValW-1:0]        val_ram_q;
  logic [IdxW-1:0]        link_rd;
  logic signed [ValW-1:0] val_rd;
  logic [IdxW-1:0]        wr_link;
  msp_pkg::op_flags_t     flags;

  assign accept     = in_valid_i && in_ready_o;
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  // stack id modulo the stack count, a few narrow subtractions
  always_comb begin
    sid_red = stack_id_i;
    for (int k = 0; k < 3; k++) begin
      if (int'(sid_red) >= NUM_STACKS) begin
        sid_red = sid_red - 2'(NUM_STACKS);
      end
    end
  end
  assign acc_sid = SidW'(sid_red);

  msp_list #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_SLOTS (POOL_SLOTS)
  ) u_list (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .commit_i   (adv),
    .s1_func_i  (s1_func_q),
    .s1_sid_i   (s1_sid_q),
    .s1_slot_i  (s1_slot_q),
    .link_rd_i  (link_rd),
    .acc_func_i (func_i),
    .acc_sid_i  (acc_sid),
    .rd_slot_o  (rd_slot),
    .fwd_hit_o  (fwd_hit),
    .fwd_link_o (fwd_link),
    .wr_link_o  (wr_link),
    .flags_o    (flags)
  );

  // per-slot links
  msp_ram #(
    .WIDTH (IdxW),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (adv && (flags.push_ok || flags.pop_ok)),
    .waddr_i (s1_slot_q[AddrW-1:0]),
    .wdata_i (wr_link),
    .re_i    (accept),
    .raddr_i (rd_slot[AddrW-1:0]),
    .rdata_o (link_ram_q)
  );

  // per-slot values
  msp_ram #(
    .WIDTH (ValW),
    .DEPTH (POOL_SLOTS)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (adv && flags.push_ok),
    .waddr_i (s1_slot_q[AddrW-1:0]),
    .wdata_i (s1_value_q),
    .re_i    (accept),
    .raddr_i (rd_slot[AddrW-1:0]),
    .rdata_o (val_ram_q)
  );

  // forwarded data wins over the RAM when the slot was written on the read edge or was never used
  assign link_rd = s1_fwd_q ? s1_fwd_link_q : link_ram_q;
  assign val_rd  = s1_fwd_q ? s1_fwd_val_q : val_ram_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q     <= func_i;
      s1_sid_q      <= acc_sid;
      s1_value_q    <= item_value_i;
      s1_slot_q     <= rd_slot;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_link_q <= fwd_link;
      s1_fwd_val_q  <= s1_value_q;
    end
    if (adv) begin
      popped_q <= flags.pop_ok ? val_rd : '0;
      status_q <= flags.status;
      empty_q  <= flags.stack_empty;
      full_q   <= flags.pool_full;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign stack_empty_o  = empty_q;
  assign pool_full_o    = full_q;

endmodule

### src/msp_chk.sv
module msp_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [msp_pkg::VALUE_W-1:0] popped_value_o,
  input logic [1:0]                        status_o,
  input logic                              stack_empty_o,
  input logic                              pool_full_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(popped_value_o)
                                    && $stable(status_o))
    else $error("result changed while stalled");

  // a rejected push only happens on a full pool
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == msp_pkg::STATUS_OVERFLOW) |-> pool_full_o)
    else $error("overflow reported with free slots left");

  // a rejected pop only happens on an empty stack
  a_unf_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == msp_pkg::STATUS_UNDERFLOW) |-> stack_empty_o)
    else $error("underflow reported on a non-empty stack");

  // failed operations return zero
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != msp_pkg::STATUS_OK) |-> (popped_value_o == '0))
    else $error("nonzero value on a failed operation");

endmodule

bind multi_stack_shared_pool_unit msp_chk u_msp_chk (.*);
